/* sv/cpig_pkg.sv */
// ----------------------------------------------------------------------------
// cpig_pkg
// Shared types and constants of the particle identification gate: field
// widths, register indexes and reset values, operation and hit-type codes,
// and the packed layouts of one hit transaction and one result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

package cpig_pkg;

    localparam int CHARGE_W      = 16;
    localparam int COORD_W       = 20;
    localparam int DET_W         = 5;
    localparam int SLOT_W        = 4;
    localparam int TALLY_W       = 6;
    localparam int CFG_IDX_W     = 3;
    localparam int SLOTS_PER_DET = 16;
    localparam int CLASSES       = 2;
    localparam int CORNERS       = 4;
    localparam int CLASS_SLOTS   = 8;
    // vertex minus point, its products and the cross product
    localparam int DIFF_W        = COORD_W + 1;
    localparam int PROD_W        = 2 * DIFF_W;
    localparam int CROSS_W       = PROD_W + 1;

    localparam logic [TALLY_W-1:0] TALLY_MAX = 6'd63;

    localparam logic OP_VERTEX = 1'b0;
    localparam logic OP_HIT    = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_Q1_MAX = 3'd0,
        REG_Q2_MIN = 3'd1,
        REG_Q2_MAX = 3'd2,
        REG_Q3_MIN = 3'd3,
        REG_Q3_MAX = 3'd4,
        REG_Q4_MIN = 3'd5
    } t_reg_idx;

    localparam logic [CHARGE_W-1:0] Q1_MAX_RST = 16'd10000;
    localparam logic [CHARGE_W-1:0] Q2_MIN_RST = 16'd6000;
    localparam logic [CHARGE_W-1:0] Q2_MAX_RST = 16'd9000;
    localparam logic [CHARGE_W-1:0] Q3_MIN_RST = 16'd3500;
    localparam logic [CHARGE_W-1:0] Q3_MAX_RST = 16'd5000;
    localparam logic [CHARGE_W-1:0] Q4_MIN_RST = 16'd10000;

    typedef enum logic [1:0] {
        HIT_NONE   = 2'd0,
        HIT_PROTON = 2'd1,
        HIT_ALPHA  = 2'd2
    } t_hit_type;

    typedef struct packed {
        logic                       op;
        logic [DET_W-1:0]           det_id;
        logic [SLOT_W-1:0]          vertex_slot;
        logic signed [COORD_W-1:0]  vertex_value;
        logic [CHARGE_W-1:0]        charge_one;
        logic [CHARGE_W-1:0]        charge_two;
        logic [CHARGE_W-1:0]        charge_three;
        logic [CHARGE_W-1:0]        charge_four;
        logic                       last_hit;
    } t_hit_item;

    typedef struct packed {
        t_hit_type                  hit_type;
        logic [DET_W-1:0]           hit_detector;
        logic [TALLY_W-1:0]         proton_count;
        logic [TALLY_W-1:0]         alpha_count;
        logic                       event_last;
        logic                       event_keep;
    } t_res_item;

endpackage

`default_nettype wire

/* sv/cpig_stream_if.sv */
// ----------------------------------------------------------------------------
// cpig_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpig_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* sv/csi_particle_id_gate.sv */
// ----------------------------------------------------------------------------
// csi_particle_id_gate
// Path: an accepted hit is registered in stages 1, 2 and 3, then in the result register.
// Throughput: one transaction (hit or vertex load) per cycle, sustained;
// the stage chain stalls only when the result register is held by the sink.
// Reset: synchronous; clears thresholds to defaults, tallies, pipeline
// valids and the per-detector row-valid bits. No clearing pass is run.
// ----------------------------------------------------------------------------
`default_nettype none

module csi_particle_id_gate #(
    parameter int DETECTOR_COUNT = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [cpig_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [cpig_pkg::CHARGE_W-1:0]  i_cfg_data,
    cpig_stream_if.sink                         i_hit,
    cpig_stream_if.source                       o_res
);

    // One memory row holds all 16 vertex coordinates of one detector:
    // proton quad in the low eight lanes, alpha quad in the high eight,
    // lane = corner*2 + axis inside each class.
    localparam int ADDR_W = (DETECTOR_COUNT > 1) ? $clog2(DETECTOR_COUNT) : 1;
    localparam int ROW_W  = cpig_pkg::SLOTS_PER_DET * cpig_pkg::COORD_W;

    // ------------------------------------------------------------------
    // Threshold registers
    // ------------------------------------------------------------------
    logic [cpig_pkg::CHARGE_W-1:0] r_q1_max;
    logic [cpig_pkg::CHARGE_W-1:0] r_q2_min;
    logic [cpig_pkg::CHARGE_W-1:0] r_q2_max;
    logic [cpig_pkg::CHARGE_W-1:0] r_q3_min;
    logic [cpig_pkg::CHARGE_W-1:0] r_q3_max;
    logic [cpig_pkg::CHARGE_W-1:0] r_q4_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1_max <= cpig_pkg::Q1_MAX_RST;
            r_q2_min <= cpig_pkg::Q2_MIN_RST;
            r_q2_max <= cpig_pkg::Q2_MAX_RST;
            r_q3_min <= cpig_pkg::Q3_MIN_RST;
            r_q3_max <= cpig_pkg::Q3_MAX_RST;
            r_q4_min <= cpig_pkg::Q4_MIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cpig_pkg::REG_Q1_MAX: r_q1_max <= i_cfg_data;
                cpig_pkg::REG_Q2_MIN: r_q2_min <= i_cfg_data;
                cpig_pkg::REG_Q2_MAX: r_q2_max <= i_cfg_data;
                cpig_pkg::REG_Q3_MIN: r_q3_min <= i_cfg_data;
                cpig_pkg::REG_Q3_MAX: r_q3_max <= i_cfg_data;
                cpig_pkg::REG_Q4_MIN: r_q4_min <= i_cfg_data;
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage advances when it is empty or its
    // successor advances, so bubbles close up behind a stalled result.
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_s3_valid;
    logic r_o_valid;

    logic adv_o;
    logic adv3;
    logic adv2;
    logic adv1;

    assign adv_o = !r_o_valid || o_res.ready;
    assign adv3  = !r_s3_valid || adv_o;
    assign adv2  = !r_s2_valid || adv3;
    assign adv1  = !r_s1_valid || adv2;

    assign i_hit.ready = adv1;

    // ------------------------------------------------------------------
    // Stage 0: accept, window cuts, point mapping, memory access
    // ------------------------------------------------------------------
    cpig_pkg::t_hit_item in_item;
    logic                in_acc;
    logic                in_range;
    logic [ADDR_W-1:0]   in_idx;
    logic                cuts_ok;
    logic                load_s1;
    logic                vtx_we;

    assign in_item  = i_hit.payload;
    assign in_acc   = i_hit.valid && i_hit.ready;
    assign in_range = (32'(in_item.det_id) < DETECTOR_COUNT);
    assign in_idx   = ADDR_W'(in_item.det_id);
    assign load_s1  = in_acc && (in_item.op == cpig_pkg::OP_HIT);
    assign vtx_we   = in_acc && (in_item.op == cpig_pkg::OP_VERTEX) && in_range;

    assign cuts_ok = !((in_item.charge_one   > r_q1_max) ||
                       (in_item.charge_two   < r_q2_min) ||
                       (in_item.charge_two   > r_q2_max) ||
                       (in_item.charge_three < r_q3_min) ||
                       (in_item.charge_three > r_q3_max) ||
                       (in_item.charge_four  < r_q4_min));

    // X = 6*(q4 - q1), Y = 3*q2 - 2*q1; both fit 20 bits signed.
    logic signed [cpig_pkg::COORD_W-1:0] q1_ext;
    logic signed [cpig_pkg::COORD_W-1:0] q2_ext;
    logic signed [cpig_pkg::COORD_W-1:0] q4_ext;
    logic signed [cpig_pkg::COORD_W-1:0] q_diff;
    logic signed [cpig_pkg::COORD_W-1:0] pt_x;
    logic signed [cpig_pkg::COORD_W-1:0] pt_y;

    assign q1_ext = cpig_pkg::COORD_W'(in_item.charge_one);
    assign q2_ext = cpig_pkg::COORD_W'(in_item.charge_two);
    assign q4_ext = cpig_pkg::COORD_W'(in_item.charge_four);
    assign q_diff = q4_ext - q1_ext;
    assign pt_x   = (q_diff <<< 2) + (q_diff <<< 1);
    assign pt_y   = (q2_ext <<< 1) + q2_ext - (q1_ext <<< 1);

    // Vertex table: one row per detector, lane write enables. A row that
    // was never written reads as all zero through its valid bit; its first
    // write stores the whole row (zeros plus the new lane) and sets it.
    logic [DETECTOR_COUNT-1:0]               r_row_vld;
    logic [ROW_W-1:0]                        r_mem [DETECTOR_COUNT];
    logic [ROW_W-1:0]                        wr_row;
    logic [cpig_pkg::SLOTS_PER_DET-1:0]      lane_en;

    always_comb begin
        for (int l = 0; l < cpig_pkg::SLOTS_PER_DET; l++) begin
            wr_row[l*cpig_pkg::COORD_W +: cpig_pkg::COORD_W] =
                (cpig_pkg::SLOT_W'(l) == in_item.vertex_slot) ?
                in_item.vertex_value : '0;
            lane_en[l] = r_row_vld[in_idx] ?
                (cpig_pkg::SLOT_W'(l) == in_item.vertex_slot) : 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (vtx_we) begin
            r_row_vld[in_idx] <= 1'b1;
        end
    end

    logic [ROW_W-1:0] r_row;
    logic             r_row_ok;

    always_ff @(posedge i_clk) begin
        if (vtx_we) begin
            for (int l = 0; l < cpig_pkg::SLOTS_PER_DET; l++) begin
                if (lane_en[l]) begin
                    r_mem[in_idx][l*cpig_pkg::COORD_W +: cpig_pkg::COORD_W] <=
                        wr_row[l*cpig_pkg::COORD_W +: cpig_pkg::COORD_W];
                end
            end
        end
        if (load_s1) begin
            r_row    <= r_mem[in_idx];
            r_row_ok <= r_row_vld[in_idx];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: vertex vectors seen from the point
    // ------------------------------------------------------------------
    logic                                r_s1_pass;
    logic signed [cpig_pkg::COORD_W-1:0] r_s1_px;
    logic signed [cpig_pkg::COORD_W-1:0] r_s1_py;
    logic [cpig_pkg::DET_W-1:0]          r_s1_det;
    logic                                r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv1) begin
            r_s1_valid <= load_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_s1) begin
            r_s1_pass <= in_range && cuts_ok;
            r_s1_px   <= pt_x;
            r_s1_py   <= pt_y;
            r_s1_det  <= in_item.det_id;
            r_s1_last <= in_item.last_hit;
        end
    end

    logic [ROW_W-1:0]                   row_eff;
    logic signed [cpig_pkg::DIFF_W-1:0] s1_vx [cpig_pkg::CLASSES][cpig_pkg::CORNERS];
    logic signed [cpig_pkg::DIFF_W-1:0] s1_vy [cpig_pkg::CLASSES][cpig_pkg::CORNERS];

    assign row_eff = r_row_ok ? r_row : '0;

    always_comb begin
        for (int c = 0; c < cpig_pkg::CLASSES; c++) begin
            for (int k = 0; k < cpig_pkg::CORNERS; k++) begin
                s1_vx[c][k] = cpig_pkg::DIFF_W'($signed(
                    row_eff[(c*cpig_pkg::CLASS_SLOTS + k*2)*cpig_pkg::COORD_W
                            +: cpig_pkg::COORD_W])) - cpig_pkg::DIFF_W'(r_s1_px);
                s1_vy[c][k] = cpig_pkg::DIFF_W'($signed(
                    row_eff[(c*cpig_pkg::CLASS_SLOTS + k*2 + 1)*cpig_pkg::COORD_W
                            +: cpig_pkg::COORD_W])) - cpig_pkg::DIFF_W'(r_s1_py);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: cross product terms, one multiplier per term
    // ------------------------------------------------------------------
    logic signed [cpig_pkg::DIFF_W-1:0] r_s2_vx [cpig_pkg::CLASSES][cpig_pkg::CORNERS];
    logic signed [cpig_pkg::DIFF_W-1:0] r_s2_vy [cpig_pkg::CLASSES][cpig_pkg::CORNERS];
    logic                               r_s2_pass;
    logic [cpig_pkg::DET_W-1:0]         r_s2_det;
    logic                               r_s2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2 && r_s1_valid) begin
            r_s2_vx   <= s1_vx;
            r_s2_vy   <= s1_vy;
            r_s2_pass <= r_s1_pass;
            r_s2_det  <= r_s1_det;
            r_s2_last <= r_s1_last;
        end
    end

    logic signed [cpig_pkg::PROD_W-1:0] s2_pa [cpig_pkg::CLASSES][cpig_pkg::CORNERS];
    logic signed [cpig_pkg::PROD_W-1:0] s2_pb [cpig_pkg::CLASSES][cpig_pkg::CORNERS];

    always_comb begin
        int nk;
        for (int c = 0; c < cpig_pkg::CLASSES; c++) begin
            for (int k = 0; k < cpig_pkg::CORNERS; k++) begin
                nk = (k + 1) % cpig_pkg::CORNERS;
                s2_pa[c][k] = r_s2_vx[c][k] * r_s2_vy[c][nk];
                s2_pb[c][k] = r_s2_vy[c][k] * r_s2_vx[c][nk];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: signs, classification, event tallies
    // ------------------------------------------------------------------
    logic signed [cpig_pkg::PROD_W-1:0] r_s3_pa [cpig_pkg::CLASSES][cpig_pkg::CORNERS];
    logic signed [cpig_pkg::PROD_W-1:0] r_s3_pb [cpig_pkg::CLASSES][cpig_pkg::CORNERS];
    logic                               r_s3_pass;
    logic [cpig_pkg::DET_W-1:0]         r_s3_det;
    logic                               r_s3_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (adv3) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3 && r_s2_valid) begin
            r_s3_pa   <= s2_pa;
            r_s3_pb   <= s2_pb;
            r_s3_pass <= r_s2_pass;
            r_s3_det  <= r_s2_det;
            r_s3_last <= r_s2_last;
        end
    end

    // Inside when no two cross products have opposite strict signs;
    // an all-zero quad therefore takes every point.
    logic [cpig_pkg::CLASSES-1:0] in_quad;

    always_comb begin
        logic signed [cpig_pkg::CROSS_W-1:0] cr;
        logic                                any_neg;
        logic                                any_pos;
        for (int c = 0; c < cpig_pkg::CLASSES; c++) begin
            any_neg = 1'b0;
            any_pos = 1'b0;
            for (int k = 0; k < cpig_pkg::CORNERS; k++) begin
                cr = cpig_pkg::CROSS_W'(r_s3_pa[c][k]) -
                     cpig_pkg::CROSS_W'(r_s3_pb[c][k]);
                any_neg = any_neg || (cr < 0);
                any_pos = any_pos || (cr > 0);
            end
            in_quad[c] = !(any_neg && any_pos);
        end
    end

    logic [cpig_pkg::TALLY_W-1:0] r_proton_tally;
    logic [cpig_pkg::TALLY_W-1:0] r_alpha_tally;
    logic [cpig_pkg::TALLY_W-1:0] n_proton_tally;
    logic [cpig_pkg::TALLY_W-1:0] n_alpha_tally;
    cpig_pkg::t_hit_type          hit_type;
    cpig_pkg::t_res_item          n_o_item;
    cpig_pkg::t_res_item          r_o_item;
    logic                         load_o;

    assign load_o = adv_o && r_s3_valid;

    always_comb begin
        // proton quad takes precedence over the alpha quad
        if (!r_s3_pass) begin
            hit_type = cpig_pkg::HIT_NONE;
        end else if (in_quad[0]) begin
            hit_type = cpig_pkg::HIT_PROTON;
        end else if (in_quad[1]) begin
            hit_type = cpig_pkg::HIT_ALPHA;
        end else begin
            hit_type = cpig_pkg::HIT_NONE;
        end

        // saturate each tally at its maximum
        n_proton_tally = r_proton_tally;
        n_alpha_tally  = r_alpha_tally;
        if (hit_type == cpig_pkg::HIT_PROTON && r_proton_tally != cpig_pkg::TALLY_MAX) begin
            n_proton_tally = r_proton_tally + cpig_pkg::TALLY_W'(1);
        end
        if (hit_type == cpig_pkg::HIT_ALPHA && r_alpha_tally != cpig_pkg::TALLY_MAX) begin
            n_alpha_tally = r_alpha_tally + cpig_pkg::TALLY_W'(1);
        end

        n_o_item.hit_type     = hit_type;
        n_o_item.hit_detector = r_s3_det;
        n_o_item.proton_count = n_proton_tally;
        n_o_item.alpha_count  = n_alpha_tally;
        n_o_item.event_last   = r_s3_last;
        n_o_item.event_keep   = r_s3_last &&
                                ((n_proton_tally != '0) || (n_alpha_tally != '0));
    end

    // Tallies advance only as a result enters the output register, so they
    // follow hit order; clear both once the last hit of an event reports.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proton_tally <= '0;
            r_alpha_tally  <= '0;
        end else if (load_o) begin
            r_proton_tally <= r_s3_last ? '0 : n_proton_tally;
            r_alpha_tally  <= r_s3_last ? '0 : n_alpha_tally;
        end
    end

    // ------------------------------------------------------------------
    // Result register: hold until the sink takes the transaction
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv_o) begin
            r_o_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_o) begin
            r_o_item <= n_o_item;
        end
    end

    assign o_res.valid   = r_o_valid;
    assign o_res.payload = r_o_item;

endmodule

`default_nettype wire

/* sv/cpig_checker.sv */
// ----------------------------------------------------------------------------
// cpig_checker
// Port-level checks on the result channel of the particle identification
// gate, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module cpig_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_res_valid,
    input wire logic                i_res_ready,
    input wire cpig_pkg::t_res_item i_res_item
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_item))
        else $error("result changed while stalled");

    // keep is reported only on the last hit, and then whenever a count is set
    a_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_item.event_keep == (i_res_item.event_last &&
            ((i_res_item.proton_count != '0) || (i_res_item.alpha_count != '0)))))
        else $error("event keep does not match counts");

    // a classified hit is already in its own tally
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |->
            ((i_res_item.hit_type != cpig_pkg::HIT_PROTON) ||
             (i_res_item.proton_count != '0)) &&
            ((i_res_item.hit_type != cpig_pkg::HIT_ALPHA) ||
             (i_res_item.alpha_count != '0)))
        else $error("classified hit missing from tally");

    // no result right after reset
    a_rst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_res_valid)
        else $error("result valid out of reset");

endmodule

bind csi_particle_id_gate cpig_checker u_cpig_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_item  (o_res.payload)
);

`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the particle identification gate. A queue of hit
// and vertex-load transactions feeds a valid/ready driver; every accepted
// transaction runs through a local scoreboard model (charge windows, quad
// containment by cross-product signs, saturating per-event tallies) and the
// predicted result is compared field by field with what the gate returns.
// The run walks through default, mid-range, wide-open, pinned and random
// threshold settings. Idle gaps fall on both channels.
// ----------------------------------------------------------------------------
module tb;

    import cpig_pkg::*;

    localparam int DET_TOTAL      = 32;
    localparam int REG_COUNT      = 6;
    localparam int HITS_PER_PHASE = 110;
    localparam int PHASES         = 5;
    localparam int ACTIVE_DETS    = 4;
    localparam int SETTLE_CYCLES  = 8;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int CALM_FROM      = 400;
    localparam int CALM_TO        = 700;
    localparam int CHARGE_TOP     = 65535;
    localparam longint COORD_HI   = 524287;
    localparam longint COORD_LO   = -524288;

    // indexes past the last threshold: writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CHARGE_W-1:0]  i_cfg_data;

    cpig_stream_if #(.t_payload(t_hit_item)) hit_ch ();
    cpig_stream_if #(.t_payload(t_res_item)) res_ch ();

    csi_particle_id_gate #(
        .DETECTOR_COUNT(DET_TOTAL)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_hit      (hit_ch),
        .o_res      (res_ch)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Scoreboard model state: thresholds, vertex table, event tallies
    // ------------------------------------------------------------------
    logic [CHARGE_W-1:0]       cfg_lim [REG_COUNT];
    logic signed [COORD_W-1:0] corner_tab [DET_TOTAL*SLOTS_PER_DET];
    logic [TALLY_W-1:0]        proton_tally;
    logic [TALLY_W-1:0]        alpha_tally;

    t_hit_item outbound_items [$];
    t_res_item pending_results [$];
    int        queued_count   = 0;
    int        accepted_count = 0;
    int        mismatches     = 0;
    int        cycle_count    = 0;
    bit        calm;

    // stimulus bookkeeping: the charges each planted quad was built around
    int anchor_q [DET_TOTAL][CLASSES][4];
    int active_det [ACTIVE_DETS];

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------

    // Point is inside when the four cross products of consecutive corner
    // vectors, seen from the point, share one sign (zeros count as both).
    function automatic bit within_quad(int det, int cls, longint px, longint py);
        longint dx [CORNERS];
        longint dy [CORNERS];
        longint cr;
        int     base;
        int     n;
        bit     no_neg = 1'b1;
        bit     no_pos = 1'b1;
        base = det * SLOTS_PER_DET + cls * CLASS_SLOTS;
        for (int k = 0; k < CORNERS; k++) begin
            dx[k] = longint'(corner_tab[base + 2*k]) - px;
            dy[k] = longint'(corner_tab[base + 2*k + 1]) - py;
        end
        for (int k = 0; k < CORNERS; k++) begin
            n  = (k + 1) % CORNERS;
            cr = dx[k] * dy[n] - dy[k] * dx[n];
            if (cr < 0) no_neg = 1'b0;
            if (cr > 0) no_pos = 1'b0;
        end
        return no_neg || no_pos;
    endfunction

    // Apply one accepted transaction to the model; return 1 with the
    // expected result when the transaction is a hit.
    function automatic bit classify_hit(input t_hit_item it, output t_res_item res);
        longint px;
        longint py;
        bit     passed;
        res = '0;
        if (it.op == OP_VERTEX) begin
            if (int'(it.det_id) < DET_TOTAL)
                corner_tab[int'(it.det_id) * SLOTS_PER_DET + int'(it.vertex_slot)] =
                    it.vertex_value;
            return 1'b0;
        end
        passed = !(it.charge_one   > cfg_lim[REG_Q1_MAX] ||
                   it.charge_two   < cfg_lim[REG_Q2_MIN] ||
                   it.charge_two   > cfg_lim[REG_Q2_MAX] ||
                   it.charge_three < cfg_lim[REG_Q3_MIN] ||
                   it.charge_three > cfg_lim[REG_Q3_MAX] ||
                   it.charge_four  < cfg_lim[REG_Q4_MIN]);
        res.hit_type = HIT_NONE;
        if (int'(it.det_id) < DET_TOTAL && passed) begin
            px = 6 * (longint'(it.charge_four) - longint'(it.charge_one));
            py = 3 * longint'(it.charge_two) - 2 * longint'(it.charge_one);
            if (within_quad(int'(it.det_id), 0, px, py)) begin
                res.hit_type = HIT_PROTON;
                if (proton_tally < TALLY_MAX) proton_tally++;
            end else if (within_quad(int'(it.det_id), 1, px, py)) begin
                res.hit_type = HIT_ALPHA;
                if (alpha_tally < TALLY_MAX) alpha_tally++;
            end
        end
        res.hit_detector = it.det_id;
        res.proton_count = proton_tally;
        res.alpha_count  = alpha_tally;
        res.event_last   = it.last_hit;
        res.event_keep   = it.last_hit && (proton_tally != '0 || alpha_tally != '0);
        if (it.last_hit) begin
            proton_tally = '0;
            alpha_tally  = '0;
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Driver: pop the next pending transaction, hold it until accepted
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_res_item res;
        if (!i_rst_n) begin
            hit_ch.valid <= 1'b0;
        end else begin
            if (hit_ch.valid && hit_ch.ready) begin
                accepted_count++;
                if (classify_hit(hit_ch.payload, res))
                    pending_results.push_back(res);
            end
            // advance only when the slot is free; idle about 11 percent of the time, never inside the calm stretch
            if (!hit_ch.valid || hit_ch.ready) begin
                if (outbound_items.size() != 0 && (calm || $urandom_range(99, 0) >= 11)) begin
                    hit_ch.valid   <= 1'b1;
                    hit_ch.payload <= outbound_items.pop_front();
                end else begin
                    hit_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result transaction against the oldest prediction
    // ------------------------------------------------------------------
    function automatic string describe(t_res_item r);
        return $sformatf("type %0d det %0d protons %0d alphas %0d last %0b keep %0b",
                         r.hit_type, r.hit_detector, r.proton_count, r.alpha_count,
                         r.event_last, r.event_keep);
    endfunction

    always @(posedge i_clk) begin
        t_res_item want;
        t_res_item got;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got = res_ch.payload;
                if (pending_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("cycle %0d: unexpected result: %s", cycle_count,
                                 describe(got));
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.hit_type !== want.hit_type ||
                        got.hit_detector !== want.hit_detector ||
                        got.proton_count !== want.proton_count ||
                        got.alpha_count !== want.alpha_count ||
                        got.event_last !== want.event_last ||
                        got.event_keep !== want.event_keep) begin
                        if (mismatches < 10)
                            $display("cycle %0d: expected %s, got %s", cycle_count,
                                     describe(want), describe(got));
                        mismatches++;
                    end
                end
            end
            // stall about 11 percent of the time, never inside the calm stretch
            res_ch.ready <= calm || $urandom_range(99, 0) >= 11;
        end
    end

    // ------------------------------------------------------------------
    // Cycle counter and watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    assign calm = cycle_count >= CALM_FROM && cycle_count < CALM_TO;

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_item(t_hit_item it);
        outbound_items.push_back(it);
        queued_count++;
    endtask

    // Random payload with op and end-of-event marker forced.
    function automatic t_hit_item noise_item(logic op, logic last);
        logic [95:0] raw;
        t_hit_item   it;
        raw = {$urandom, $urandom, $urandom};
        it  = raw[$bits(t_hit_item)-1:0];
        it.op       = op;
        it.last_hit = last;
        return it;
    endfunction

    function automatic t_hit_item hit_item(int det, int q1, int q2, int q3, int q4,
                                           logic last);
        t_hit_item it;
        it = noise_item(OP_HIT, last);
        it.det_id       = DET_W'(det);
        it.charge_one   = CHARGE_W'(q1);
        it.charge_two   = CHARGE_W'(q2);
        it.charge_three = CHARGE_W'(q3);
        it.charge_four  = CHARGE_W'(q4);
        return it;
    endfunction

    function automatic t_hit_item vertex_item(int det, int slot, longint value, logic last);
        t_hit_item it;
        it = noise_item(OP_VERTEX, last);
        it.det_id      = DET_W'(det);
        it.vertex_slot = SLOT_W'(slot);
        if (value > COORD_HI) value = COORD_HI;
        if (value < COORD_LO) value = COORD_LO;
        it.vertex_value = value[COORD_W-1:0];
        return it;
    endfunction

    // Uniform pick in [lo, hi]; an inverted window falls back to any charge.
    function automatic int pick_between(int lo, int hi);
        if (lo > hi) return int'($urandom_range(CHARGE_TOP, 0));
        return int'($urandom_range(hi, lo));
    endfunction

    // Jitter a charge around its anchor, kept inside the window when there is one.
    function automatic int nudge(int base, int spread, int lo, int hi);
        int v;
        if (lo > hi) begin
            lo = 0;
            hi = CHARGE_TOP;
        end
        v = base + int'($urandom_range(2*spread, 0)) - spread;
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v;
    endfunction

    // Pick an in-window anchor hit for (det, cls) and load a quad around its
    // point: a rectangle or a diamond, wound either way.
    task automatic plant_quad(int det, int cls);
        int     q [4];
        longint cx;
        longint cy;
        longint hx;
        longint hy;
        longint vx [CORNERS];
        longint vy [CORNERS];
        longint tmp;
        q[0] = pick_between(0, int'(cfg_lim[REG_Q1_MAX]));
        q[1] = pick_between(int'(cfg_lim[REG_Q2_MIN]), int'(cfg_lim[REG_Q2_MAX]));
        q[2] = pick_between(int'(cfg_lim[REG_Q3_MIN]), int'(cfg_lim[REG_Q3_MAX]));
        q[3] = pick_between(int'(cfg_lim[REG_Q4_MIN]), CHARGE_TOP);
        for (int i = 0; i < 4; i++) anchor_q[det][cls][i] = q[i];
        cx = 6 * (longint'(q[3]) - longint'(q[0]));
        cy = 3 * longint'(q[1]) - 2 * longint'(q[0]);
        hx = longint'($urandom_range(6000, 1000));
        hy = longint'($urandom_range(6000, 1000));
        if ($urandom_range(1, 0)) begin
            vx = '{cx - hx, cx + hx, cx + hx, cx - hx};
            vy = '{cy - hy, cy - hy, cy + hy, cy + hy};
        end else begin
            vx = '{cx, cx + hx, cx, cx - hx};
            vy = '{cy - hy, cy, cy + hy, cy};
        end
        if ($urandom_range(1, 0)) begin
            tmp = vx[1]; vx[1] = vx[3]; vx[3] = tmp;
            tmp = vy[1]; vy[1] = vy[3]; vy[3] = tmp;
        end
        for (int k = 0; k < CORNERS; k++) begin
            queue_item(vertex_item(det, cls*CLASS_SLOTS + 2*k, vx[k],
                                   1'($urandom_range(1, 0))));
            queue_item(vertex_item(det, cls*CLASS_SLOTS + 2*k + 1, vy[k],
                                   1'($urandom_range(1, 0))));
        end
    endtask

    // Hit jittered around the anchor of src_det, sent under detector det.
    task automatic queue_hit(int det, int src_det, int cls, int spread, logic last);
        queue_item(hit_item(det,
            nudge(anchor_q[src_det][cls][0], spread, 0, int'(cfg_lim[REG_Q1_MAX])),
            nudge(anchor_q[src_det][cls][1], spread, int'(cfg_lim[REG_Q2_MIN]),
                  int'(cfg_lim[REG_Q2_MAX])),
            nudge(anchor_q[src_det][cls][2], spread, int'(cfg_lim[REG_Q3_MIN]),
                  int'(cfg_lim[REG_Q3_MAX])),
            nudge(anchor_q[src_det][cls][3], spread, int'(cfg_lim[REG_Q4_MIN]),
                  CHARGE_TOP),
            last));
    endtask

    // Events of random length over a few freshly loaded detectors. Long
    // events stay tight on one proton quad so the tallies saturate.
    task automatic run_traffic(int phase);
        int left;
        int len;
        int spread;
        int roll;
        int det;
        int cls;
        bit long_ev;
        bit first;
        for (int k = 0; k < ACTIVE_DETS; k++) begin
            active_det[k] = $urandom_range(DET_TOTAL-1, 0);
            plant_quad(active_det[k], 0);
            plant_quad(active_det[k], 1);
        end
        left  = HITS_PER_PHASE;
        first = 1'b1;
        while (left > 0) begin
            long_ev = (first && phase % 2 == 1) || $urandom_range(11, 0) == 0;
            len     = long_ev ? $urandom_range(80, 66) : $urandom_range(8, 1);
            spread  = long_ev ? 40 : $urandom_range(1500, 0);
            for (int k = 0; k < len; k++) begin
                roll = $urandom_range(99, 0);
                det  = active_det[$urandom_range(ACTIVE_DETS-1, 0)];
                cls  = $urandom_range(1, 0);
                if (long_ev) begin
                    queue_hit(active_det[0], active_det[0], 0, spread, k == len-1);
                end else begin
                    // stray vertex load slipped in ahead of the hit
                    if (roll < 4)
                        queue_item(noise_item(OP_VERTEX, 1'($urandom_range(1, 0))));
                    if (roll >= 4 && roll < 14)
                        queue_item(noise_item(OP_HIT, k == len-1));
                    else if (roll < 22)
                        queue_hit($urandom_range(DET_TOTAL-1, 0), det, cls, spread,
                                  k == len-1);
                    else
                        queue_hit(det, det, cls, spread, k == len-1);
                end
            end
            left  -= len;
            first  = 1'b0;
        end
    endtask

    // Wait until every queued transaction is accepted and every result has
    // come back, then let the pipeline flush trailing vertex loads.
    task automatic drain();
        while (!(accepted_count == queued_count && pending_results.size() == 0))
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Hold write enable across back-to-back writes; caller drops it.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CHARGE_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        if (idx < REG_COUNT) cfg_lim[idx] = value;
    endtask

    task automatic configure(int phase);
        logic [CHARGE_W-1:0] val [REG_COUNT];
        int lo;
        case (phase)
            1: begin
                // mid-range, well-formed windows
                val[REG_Q1_MAX] = CHARGE_W'($urandom_range(30000, 2000));
                lo              = $urandom_range(20000, 0);
                val[REG_Q2_MIN] = CHARGE_W'(lo);
                val[REG_Q2_MAX] = CHARGE_W'(lo + $urandom_range(30000, 0));
                lo              = $urandom_range(20000, 0);
                val[REG_Q3_MIN] = CHARGE_W'(lo);
                val[REG_Q3_MAX] = CHARGE_W'(lo + $urandom_range(30000, 0));
                val[REG_Q4_MIN] = CHARGE_W'($urandom_range(40000, 0));
            end
            2: begin
                // wide open: every charge passes
                val[REG_Q1_MAX] = CHARGE_W'(CHARGE_TOP);
                val[REG_Q2_MIN] = '0;
                val[REG_Q2_MAX] = CHARGE_W'(CHARGE_TOP);
                val[REG_Q3_MIN] = '0;
                val[REG_Q3_MAX] = CHARGE_W'(CHARGE_TOP);
                val[REG_Q4_MIN] = '0;
            end
            3: begin
                // pinned: only one charge value per window passes
                val[REG_Q1_MAX] = '0;
                val[REG_Q2_MIN] = CHARGE_W'(CHARGE_TOP);
                val[REG_Q2_MAX] = CHARGE_W'(CHARGE_TOP);
                val[REG_Q3_MIN] = CHARGE_W'(CHARGE_TOP);
                val[REG_Q3_MAX] = CHARGE_W'(CHARGE_TOP);
                val[REG_Q4_MIN] = CHARGE_W'(CHARGE_TOP);
            end
            default: begin
                // anything, inverted windows included
                for (int r = 0; r < REG_COUNT; r++) val[r] = CHARGE_W'($urandom);
            end
        endcase
        for (int r = 0; r < REG_COUNT; r++) write_reg(CFG_IDX_W'(r), val[r]);
        if (phase == 2) begin
            write_reg(REG_SPARE_LO, CHARGE_W'($urandom));
            write_reg(REG_SPARE_HI, CHARGE_W'($urandom));
        end
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        hit_ch.valid   = 1'b0;
        hit_ch.payload = '0;
        res_ch.ready   = 1'b0;

        cfg_lim[REG_Q1_MAX] = Q1_MAX_RST;
        cfg_lim[REG_Q2_MIN] = Q2_MIN_RST;
        cfg_lim[REG_Q2_MAX] = Q2_MAX_RST;
        cfg_lim[REG_Q3_MIN] = Q3_MIN_RST;
        cfg_lim[REG_Q3_MAX] = Q3_MAX_RST;
        cfg_lim[REG_Q4_MIN] = Q4_MIN_RST;
        for (int i = 0; i < DET_TOTAL*SLOTS_PER_DET; i++) corner_tab[i] = '0;
        proton_tally = '0;
        alpha_tally  = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty quads accept anything that survives the cuts; hit the
        // window corners at the defaults.
        queue_item(hit_item(0, 0, 6000, 3500, 10000, 1'b0));
        queue_item(hit_item(DET_TOTAL-1, 10000, 9000, 5000, CHARGE_TOP, 1'b1));
        // extreme charges, rejected; event closes with nothing kept
        queue_item(hit_item(7, CHARGE_TOP, 0, 0, 0, 1'b1));
        // every cut but the charge-one maximum missed by one count
        queue_item(hit_item(1, 5000, 5999, 4000, 20000, 1'b0));
        queue_item(hit_item(1, 5000, 9001, 4000, 20000, 1'b0));
        queue_item(hit_item(1, 5000, 7500, 3499, 20000, 1'b0));
        queue_item(hit_item(1, 5000, 7500, 5001, 20000, 1'b0));
        queue_item(hit_item(1, 5000, 7500, 4000, 9999, 1'b1));
        // proton square around (90000, 12500) on detector 5; a load carrying
        // the end-of-event marker must leave the tallies alone
        queue_item(vertex_item(5, 0, 87000, 1'b0));
        queue_item(vertex_item(5, 1, 9500, 1'b0));
        queue_item(vertex_item(5, 2, 93000, 1'b0));
        queue_item(vertex_item(5, 3, 9500, 1'b0));
        queue_item(vertex_item(5, 4, 93000, 1'b0));
        queue_item(vertex_item(5, 5, 15500, 1'b0));
        queue_item(vertex_item(5, 6, 87000, 1'b0));
        queue_item(vertex_item(5, 7, 15500, 1'b1));
        queue_item(hit_item(5, 5000, 7500, 4000, 20000, 1'b0));   // centre
        queue_item(hit_item(5, 5000, 7500, 4000, 19500, 1'b0));   // on the left edge
        queue_item(hit_item(5, 5000, 7500, 4000, 25000, 1'b0));   // outside, empty alpha
        // alpha quad with coordinates at both ends of the range
        queue_item(vertex_item(5, CLASS_SLOTS, COORD_LO, 1'b0));
        queue_item(vertex_item(5, CLASS_SLOTS + 5, COORD_HI, 1'b0));
        queue_item(hit_item(5, 5000, 7500, 4000, 25000, 1'b1));
        queue_item(vertex_item(2, 0, COORD_HI, 1'b1));

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                drain();
                configure(phase);
            end
            run_traffic(phase);
        end
        drain();

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
